### hw/rtl/fftr2_pkg.sv
package fftr2_pkg;

  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_TWIDDLE_BITS = 16;
  localparam int SAMPLE_W         = 16;
  localparam int BIN_W            = 32;
  localparam int BIN_NUM_W        = 10;
  localparam int CFG_W            = 4;
  localparam int LOG2_RESET       = 10;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  localparam logic [2:0] BF_NOP    = 3'd0;
  localparam logic [2:0] BF_LOAD_B = 3'd1;
  localparam logic [2:0] BF_MUL0   = 3'd2;
  localparam logic [2:0] BF_MUL1   = 3'd3;
  localparam logic [2:0] BF_MUL2   = 3'd4;
  localparam logic [2:0] BF_MUL3   = 3'd5;
  localparam logic [2:0] BF_FIN    = 3'd6;
  localparam logic [2:0] BF_RND    = 3'd7;

  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample_re;
    logic [SAMPLE_W-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]     bin_re;
    logic [BIN_W-1:0]     bin_im;
    logic [BIN_NUM_W-1:0] bin_number;
    logic                 last_bin;
    logic                 status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op;
  } bf_ctrl_t;

endpackage

### hw/rtl/fftr2_ram.sv
module fftr2_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fftr2_twiddle_rom.sv
module fftr2_twiddle_rom #(
  parameter int MAX_POINTS   = 1024,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic [((MAX_POINTS > 2) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] addr,
  output logic signed [TWIDDLE_BITS-1:0] cos_q,
  output logic signed [TWIDDLE_BITS-1:0] sin_q
);

  localparam int LW    = $clog2(MAX_POINTS);
  localparam int DEPTH = MAX_POINTS / 2;
  localparam int SHR   = 30 - (TWIDDLE_BITS - 1);
  localparam logic signed [63:0] TOP = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 64'sd1;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic [2*TWIDDLE_BITS-1:0] row_t;
  typedef row_t tab_t [DEPTH];

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] taylor(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] d;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum  = signed'(term);
    for (int n = 1; n <= 12; n++) begin
      d    = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = udiv((term * x2) >> 30, d);
      if ((n & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  function automatic logic signed [TWIDDLE_BITS-1:0] to_tw(input logic signed [63:0] q);
    logic signed [63:0] v;
    v = (q < 0) ? 64'sd0 : q;
    v = (v + (64'sd1 <<< (SHR - 1))) >>> SHR;
    if (v > TOP) begin
      v = TOP;
    end
    return TWIDDLE_BITS'(v);
  endfunction

  function automatic tab_t make_tab();
    tab_t tab;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] phi;
    logic signed [TWIDDLE_BITS-1:0] c;
    logic signed [TWIDDLE_BITS-1:0] s;
    for (int k = 0; k < DEPTH; k++) begin
      t   = 64'(k) * 64'd4;
      r   = t & 64'(MAX_POINTS - 1);
      phi = (r * PI_HALF_Q30 + 64'(DEPTH)) >> LW;
      c   = to_tw(taylor(phi, 1'b0));
      s   = to_tw(taylor(phi, 1'b1));
      if ((t >> LW) == 64'd0) begin
        tab[k] = {c, s};
      end else begin
        tab[k] = {-s, c};
      end
    end
    return tab;
  endfunction

  localparam tab_t TAB = make_tab();

  always_ff @(posedge clk) begin
    {cos_q, sin_q} <= TAB[addr];
  end

endmodule

### hw/rtl/fftr2_bfly.sv
module fftr2_bfly import fftr2_pkg::*; #(
  parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
  input  logic                           clk,
  input  bf_ctrl_t                       ctrl,
  input  logic [2*BIN_W-1:0]             rdata,
  input  logic signed [TWIDDLE_BITS-1:0] cos_q,
  input  logic signed [TWIDDLE_BITS-1:0] sin_q,
  output logic [2*BIN_W-1:0]             sum_word,
  output logic [2*BIN_W-1:0]             diff_word
);

  localparam int PW   = BIN_W + TWIDDLE_BITS;
  localparam int ACW  = PW + 1;
  localparam int TW_W = ACW - (TWIDDLE_BITS - 1);
  localparam int SW   = TW_W + 1;
  localparam logic signed [ACW-1:0] RND_C = ACW'(1) << (TWIDDLE_BITS - 2);
  localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(BIN_W-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [BIN_W-1:0]        br, bi, ar, ai;
  logic signed [TWIDDLE_BITS-1:0] c, s;
  logic signed [PW-1:0]           prod;
  logic signed [ACW-1:0]          acc_r, acc_i;
  logic signed [TW_W-1:0]         t_r, t_i;

  function automatic logic [BIN_W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SMAX) begin
      return SMAX[BIN_W-1:0];
    end else if (v < SMIN) begin
      return SMIN[BIN_W-1:0];
    end
    return v[BIN_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    case (ctrl.op)
      BF_LOAD_B: begin
        br <= rdata[2*BIN_W-1:BIN_W];
        bi <= rdata[BIN_W-1:0];
        c  <= cos_q;
        s  <= sin_q;
      end
      BF_MUL0: begin
        ar   <= rdata[2*BIN_W-1:BIN_W];
        ai   <= rdata[BIN_W-1:0];
        prod <= br * c;
      end
      BF_MUL1: begin
        acc_r <= ACW'(prod);
        prod  <= bi * s;
      end
      BF_MUL2: begin
        acc_r <= acc_r + ACW'(prod);
        prod  <= bi * c;
      end
      BF_MUL3: begin
        acc_i <= ACW'(prod);
        prod  <= br * s;
      end
      BF_FIN: begin
        acc_i <= acc_i - ACW'(prod);
      end
      BF_RND: begin
        t_r <= TW_W'((acc_r + RND_C) >>> (TWIDDLE_BITS - 1));
        t_i <= TW_W'((acc_i + RND_C) >>> (TWIDDLE_BITS - 1));
      end
      default: begin
      end
    endcase
  end

  assign sum_word  = {sat(SW'(ar) + SW'(t_r)), sat(SW'(ai) + SW'(t_i))};
  assign diff_word = {sat(SW'(ar) - SW'(t_r)), sat(SW'(ai) - SW'(t_i))};

endmodule

### hw/rtl/fft_radix2_inplace_top.sv
// In-place radix-2 DIT FFT, forward and unscaled, N = 2^log2_points.
// A load transaction writes the sample straight to its
// bit-reversed slot. The load that completes the frame raises busy while
// the transform runs: each butterfly makes two reads and two writes
// on the single work RAM and four passes through the one shared multiplier.
// The result of a read transaction strobes on done in the following cycle;
// reads may be issued every cycle while busy is low. The receiver cannot
// stall: a result is on the result port for exactly the one cycle that done
// is high. Configuration is taken whenever busy is low.
module fft_radix2_inplace_top import fftr2_pkg::*; #(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         cmd,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LW   = $clog2(MAX_POINTS);
  localparam int AW   = LW;
  localparam int TWA  = (MAX_POINTS > 2) ? LW - 1 : 1;
  localparam int WW   = 2 * BIN_W;
  localparam int LCAP = (LW > 15) ? 15 : LW;
  localparam int LRST = (LOG2_RESET > LW) ? LW : LOG2_RESET;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD_B = 4'd1;
  localparam logic [3:0] ST_RD_A = 4'd2;
  localparam logic [3:0] ST_M0   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_M3   = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_RND  = 4'd8;
  localparam logic [3:0] ST_WR_M = 4'd9;
  localparam logic [3:0] ST_WR_J = 4'd10;

  logic [3:0]           state;
  logic [CFG_W-1:0]     log2_pts;
  logic [AW-1:0]        load_count;
  logic [AW-1:0]        read_count;
  logic                 frame_ready;
  logic [CFG_W-1:0]     stage;
  logic [AW-1:0]        bidx;
  logic                 rd_pend;
  logic                 rd_ok;
  logic [BIN_NUM_W-1:0] rd_num;
  logic                 rd_last;

  logic [AW:0]      n_full;
  logic [AW-1:0]    nmask, blast;
  logic [CFG_W-1:0] sm1;
  logic [AW-1:0]    hbit, hmask, pos, jaddr, maddr, kfull, rev, baddr;
  logic [4:0]       k_sh;
  logic [TWA-1:0]   taddr;
  logic             accept, ld, rd, cfg_wr;
  logic [CFG_W-1:0] cfg_sat;

  logic                           we;
  logic [AW-1:0]                  waddr, raddr;
  logic [WW-1:0]                  wdata, rdata, sum_word, diff_word;
  logic signed [TWIDDLE_BITS-1:0] cos_q, sin_q;
  bf_ctrl_t                       ctrl;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && !busy;
  assign ld        = accept && (cmd.func == FUNC_LOAD);
  assign rd        = accept && (cmd.func == FUNC_READ);
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    n_full = (AW+1)'(1) << log2_pts;
    nmask  = AW'(n_full - (AW+1)'(1));
    blast  = AW'(n_full >> 1) - AW'(1);
    sm1    = stage - CFG_W'(1);
    hbit   = AW'((AW+1)'(1) << sm1);
    hmask  = hbit - AW'(1);
    pos    = bidx & hmask;
    jaddr  = ((bidx >> sm1) << stage) | pos;
    maddr  = jaddr | hbit;
    k_sh   = 5'(LW) - 5'(stage);
    kfull  = pos << k_sh;
    taddr  = TWA'(kfull);
    for (int i = 0; i < AW; i++) begin
      rev[i] = load_count[AW-1-i];
    end
    baddr = rev >> (5'(AW) - 5'(log2_pts));
    if (cfg_data < CFG_W'(1)) begin
      cfg_sat = CFG_W'(1);
    end else if (cfg_data > CFG_W'(LCAP)) begin
      cfg_sat = CFG_W'(LCAP);
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = maddr;
    wdata   = diff_word;
    raddr   = jaddr;
    ctrl.op = BF_NOP;
    case (state)
      ST_IDLE: begin
        raddr = read_count;
        we    = ld;
        waddr = baddr;
        wdata = {{(BIN_W-SAMPLE_W){cmd.sample_re[SAMPLE_W-1]}}, cmd.sample_re,
                 {(BIN_W-SAMPLE_W){cmd.sample_im[SAMPLE_W-1]}}, cmd.sample_im};
      end
      ST_RD_B: raddr = maddr;
      ST_RD_A: ctrl.op = BF_LOAD_B;
      ST_M0:   ctrl.op = BF_MUL0;
      ST_M1:   ctrl.op = BF_MUL1;
      ST_M2:   ctrl.op = BF_MUL2;
      ST_M3:   ctrl.op = BF_MUL3;
      ST_FIN:  ctrl.op = BF_FIN;
      ST_RND:  ctrl.op = BF_RND;
      ST_WR_M: we = 1'b1;
      ST_WR_J: begin
        we    = 1'b1;
        waddr = jaddr;
        wdata = sum_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      log2_pts    <= CFG_W'(LRST);
      load_count  <= '0;
      read_count  <= '0;
      frame_ready <= 1'b0;
      stage       <= '0;
      bidx        <= '0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend <= rd;
      if (rd) begin
        rd_ok   <= frame_ready;
        rd_num  <= BIN_NUM_W'(read_count);
        rd_last <= (read_count == nmask);
        if (frame_ready) begin
          read_count <= (read_count == nmask) ? '0 : read_count + AW'(1);
        end
      end
      case (state)
        ST_IDLE: begin
          if (ld) begin
            frame_ready <= 1'b0;
            if (load_count == nmask) begin
              load_count <= '0;
              stage      <= CFG_W'(1);
              bidx       <= '0;
              state      <= ST_RD_B;
            end else begin
              load_count <= load_count + AW'(1);
            end
          end
        end
        ST_RD_B: state <= ST_RD_A;
        ST_RD_A: state <= ST_M0;
        ST_M0:   state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_M3;
        ST_M3:   state <= ST_FIN;
        ST_FIN:  state <= ST_RND;
        ST_RND:  state <= ST_WR_M;
        ST_WR_M: state <= ST_WR_J;
        ST_WR_J: begin
          if (bidx == blast) begin
            bidx <= '0;
            if (stage == log2_pts) begin
              state       <= ST_IDLE;
              frame_ready <= 1'b1;
              read_count  <= '0;
            end else begin
              stage <= stage + CFG_W'(1);
              state <= ST_RD_B;
            end
          end else begin
            bidx  <= bidx + AW'(1);
            state <= ST_RD_B;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        log2_pts    <= cfg_sat;
        load_count  <= '0;
        read_count  <= '0;
        frame_ready <= 1'b0;
      end
    end
  end

  fftr2_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_POINTS)
  ) u_work (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  fftr2_twiddle_rom #(
    .MAX_POINTS  (MAX_POINTS),
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_tw (
    .clk  (clk),
    .addr (taddr),
    .cos_q(cos_q),
    .sin_q(sin_q)
  );

  fftr2_bfly #(
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_bfly (
    .clk      (clk),
    .ctrl     (ctrl),
    .rdata    (rdata),
    .cos_q    (cos_q),
    .sin_q    (sin_q),
    .sum_word (sum_word),
    .diff_word(diff_word)
  );

  always_comb begin
    result.bin_re     = rd_ok ? rdata[WW-1:BIN_W] : '0;
    result.bin_im     = rd_ok ? rdata[BIN_W-1:0] : '0;
    result.bin_number = rd_ok ? rd_num : '0;
    result.last_bin   = rd_ok && rd_last;
    result.status     = rd_ok ? STATUS_OK : STATUS_NOT_READY;
  end
  assign done = rd_pend;

  a_done_after_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_IDLE)
    else $error("result strobe not preceded by an idle cycle");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_B || state == ST_RD_A) |-> !we)
    else $error("work RAM written during butterfly read");

  a_write_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR_M |=> state == ST_WR_J)
    else $error("butterfly write pair broken");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    busy |-> !frame_ready)
    else $error("frame readable while transform runs");

endmodule
